// File: src/bitcp_pkg.sv
// Shared types and constants for the bit range copy core.
// Used by bitcp_align and bit_range_copy_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bitcp_pkg;

  localparam int DEF_BITMAP_WORDS = 16;

  localparam int WORD_W     = 64;
  localparam int WIN_W      = 2 * WORD_W;
  localparam int DIGIT_W    = 16;
  localparam int DIGITS     = WORD_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(DIGITS);
  localparam int DIG_POS_W  = $clog2(DIGIT_W);
  localparam int SH_W       = $clog2(WORD_W);
  localparam int LEN_W      = 11;
  localparam int POS_W      = LEN_W + 1;
  localparam int WI_W       = POS_W - SH_W;
  localparam int SIDX_W     = WI_W + 1;
  localparam int IDX_W      = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_LEN  = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_WR_SRC = 2'd0,
    OP_WR_DST = 2'd1,
    OP_RD_DST = 2'd2,
    OP_COPY   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_WR_OOB = 2'd1,
    ST_RD_OOB = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_CP_PLD,
    S_CP_LD,
    S_CP_DIG,
    S_CP_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_lo;
    logic load_hi;
    logic shift;
  } dp_ctrl_t;

  typedef struct packed {
    logic [SH_W-1:0]  sh;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] stop;
  } geom_t;

endpackage

`default_nettype wire

// File: src/bitcp_ram.sv
// Single write port, single registered read port word store.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module bitcp_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/bitcp_align.sv
// Digit-serial align and merge datapath: source window and destination word shift registers.
// Depends on bitcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bitcp_align (
  input  wire logic                               clk,
  input  wire bitcp_pkg::dp_ctrl_t                ctrl,
  input  wire bitcp_pkg::geom_t                   geom,
  input  wire logic [bitcp_pkg::WI_W-1:0]         wi,
  input  wire logic [bitcp_pkg::DIG_CNT_W-1:0]    dig,
  input  wire logic [bitcp_pkg::WORD_W-1:0]       src_word,
  input  wire logic [bitcp_pkg::WORD_W-1:0]       dst_word,
  output logic      [bitcp_pkg::WORD_W-1:0]       merged_word
);

  logic [bitcp_pkg::WIN_W-1:0]   win_r;
  logic [bitcp_pkg::WIN_W-1:0]   win_nxt;
  logic [bitcp_pkg::WORD_W-1:0]  dst_r;
  logic [bitcp_pkg::WORD_W-1:0]  dst_nxt;
  logic [bitcp_pkg::DIGIT_W-1:0] src_dig;
  logic [bitcp_pkg::DIGIT_W-1:0] mask;
  logic [bitcp_pkg::DIGIT_W-1:0] out_dig;
  logic [bitcp_pkg::POS_W-1:0]   pos_base;

  assign src_dig  = win_r[geom.sh +: bitcp_pkg::DIGIT_W];
  assign pos_base = {wi, dig, {bitcp_pkg::DIG_POS_W{1'b0}}};

  always_comb begin
    for (int j = 0; j < bitcp_pkg::DIGIT_W; j++) begin
      mask[j] = ((pos_base | bitcp_pkg::POS_W'(j)) >= geom.first) &&
                ((pos_base | bitcp_pkg::POS_W'(j)) < geom.stop);
    end
  end

  assign out_dig = (dst_r[bitcp_pkg::DIGIT_W-1:0] & ~mask) | (src_dig & mask);

  always_comb begin
    win_nxt = win_r;
    dst_nxt = dst_r;
    if (ctrl.load_lo) begin
      win_nxt = {{bitcp_pkg::WORD_W{1'b0}}, src_word};
    end else if (ctrl.load_hi) begin
      win_nxt = {src_word, win_r[bitcp_pkg::WORD_W-1:0]};
      dst_nxt = dst_word;
    end else if (ctrl.shift) begin
      win_nxt = win_r >> bitcp_pkg::DIGIT_W;
      dst_nxt = {out_dig, dst_r[bitcp_pkg::WORD_W-1:bitcp_pkg::DIGIT_W]};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    dst_r <= dst_nxt;
  end

  assign merged_word = dst_r;

endmodule

`default_nettype wire

// File: src/bit_range_copy_core.sv
// Top level of the bit range copy core: control sequencer, two word stores, output register.
// Depends on bitcp_pkg, bitcp_ram and bitcp_align.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   in_*  : one operation per transaction; in_tuser carries the operation code.
//   out_* : exactly one result transaction per input transaction, in order.
//   cfg_* : length register writes, always ready; write only while the core is idle.
// A copy preloads the low source window word, then handles each destination word it
// touches in turn: a load step, four 16-bit digit shifts through the align shift
// registers and a write-back on the destination store.
// One operation is in flight at a time; the next transaction is taken as soon as
// the result sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register and the sequencer waits at
// completion until it is taken.
// Reset: rst_n is synchronous, active low. Both stores are then zeroed by a
// clearing pass over every word address, during which in_tready stays low;
// configuration writes are taken throughout.

module bit_range_copy_core #(
  parameter int BITMAP_WORDS = bitcp_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: word_index[3:0], word_value[67:4], copy_length[78:68],
  //        write_offset[89:79], read_offset[100:90], zero pad [103:101]
  input  wire logic [bitcp_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: operation[1:0]
  input  wire logic [bitcp_pkg::OP_W-1:0]          in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata: read_data[63:0], status[65:64], zero pad [71:66]
  output logic      [bitcp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bitcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bitcp_pkg::LEN_W-1:0]         cfg_data
);

  localparam int ADDR_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CAP_BITS = BITMAP_WORDS * bitcp_pkg::WORD_W;
  localparam int CAP_CLIP = (CAP_BITS > 2047) ? 2047 : CAP_BITS;
  localparam logic [bitcp_pkg::LEN_W-1:0] CAP_LEN = bitcp_pkg::LEN_W'(CAP_CLIP);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);

  bitcp_pkg::state_t state_r, state_nxt;

  logic [bitcp_pkg::LEN_W-1:0]      dlen_r, dlen_nxt;
  logic [bitcp_pkg::LEN_W-1:0]      slen_r, slen_nxt;
  logic [ADDR_W-1:0]                clr_addr_r, clr_addr_nxt;

  bitcp_pkg::op_t                   op_r;
  logic [bitcp_pkg::IDX_W-1:0]      idx_r;
  logic [bitcp_pkg::WORD_W-1:0]     val_r;
  logic [bitcp_pkg::LEN_W-1:0]      cnt_r;
  logic [bitcp_pkg::LEN_W-1:0]      woff_r;
  logic [bitcp_pkg::LEN_W-1:0]      roff_r;

  bitcp_pkg::geom_t                 geom_r, geom_nxt;
  logic [bitcp_pkg::WI_W-1:0]       wi_r, wi_nxt;
  logic [bitcp_pkg::WI_W-1:0]       last_wi_r, last_wi_nxt;
  logic [bitcp_pkg::SIDX_W-1:0]     sidx_r, sidx_nxt;
  logic [bitcp_pkg::DIG_CNT_W-1:0]  dig_r, dig_nxt;
  logic [bitcp_pkg::WORD_W-1:0]     res_data_r, res_data_nxt;
  bitcp_pkg::status_t               res_status_r, res_status_nxt;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [bitcp_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                             src_we, dst_we;
  logic [ADDR_W-1:0]                src_waddr, dst_waddr, src_raddr, dst_raddr;
  logic [bitcp_pkg::WORD_W-1:0]     src_wdata, dst_wdata, src_rdata, dst_rdata;
  logic [bitcp_pkg::WORD_W-1:0]     merged_word;
  bitcp_pkg::dp_ctrl_t              dp_ctrl;

  logic [bitcp_pkg::LEN_W-1:0]      dlen_eff, slen_eff;
  logic [bitcp_pkg::POS_W-1:0]      w_ext, r_ext, cnt_ext, stop, stop_m1, diff;
  logic [bitcp_pkg::SIDX_W-1:0]     sidx0;
  logic                             idx_ok, wr_oob, rd_oob, in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // copy geometry from the held transaction
  assign dlen_eff = (dlen_r > CAP_LEN) ? CAP_LEN : dlen_r;
  assign slen_eff = (slen_r > CAP_LEN) ? CAP_LEN : slen_r;
  assign w_ext    = {1'b0, woff_r};
  assign r_ext    = {1'b0, roff_r};
  assign cnt_ext  = {1'b0, cnt_r};
  assign stop     = w_ext + cnt_ext;
  assign stop_m1  = stop - bitcp_pkg::POS_W'(1);
  assign wr_oob   = stop > {1'b0, dlen_eff};
  assign rd_oob   = (r_ext + cnt_ext) > {1'b0, slen_eff};
  assign diff     = r_ext - w_ext;
  assign sidx0    = {diff[bitcp_pkg::POS_W-1], diff[bitcp_pkg::POS_W-1:bitcp_pkg::SH_W]} +
                    {1'b0, w_ext[bitcp_pkg::POS_W-1:bitcp_pkg::SH_W]};
  assign idx_ok   = int'(idx_r) < BITMAP_WORDS;

  always_comb begin
    dlen_nxt = dlen_r;
    slen_nxt = slen_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bitcp_pkg::REG_DEST_LEN: dlen_nxt = cfg_data;
        bitcp_pkg::REG_SRC_LEN:  slen_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    geom_nxt       = geom_r;
    wi_nxt         = wi_r;
    last_wi_nxt    = last_wi_r;
    sidx_nxt       = sidx_r;
    dig_nxt        = dig_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    src_we         = 1'b0;
    dst_we         = 1'b0;
    src_waddr      = ADDR_W'(idx_r);
    dst_waddr      = ADDR_W'(idx_r);
    src_wdata      = val_r;
    dst_wdata      = val_r;
    src_raddr      = ADDR_W'(sidx_r);
    dst_raddr      = ADDR_W'(wi_r);
    dp_ctrl        = '0;

    case (state_r)
      bitcp_pkg::S_CLEAR: begin
        src_we       = 1'b1;
        dst_we       = 1'b1;
        src_waddr    = clr_addr_r;
        dst_waddr    = clr_addr_r;
        src_wdata    = '0;
        dst_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = bitcp_pkg::S_IDLE;
        end
      end
      bitcp_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          state_nxt = bitcp_pkg::S_DECODE;
        end
      end
      bitcp_pkg::S_DECODE: begin
        res_data_nxt   = '0;
        res_status_nxt = bitcp_pkg::ST_OK;
        src_raddr      = ADDR_W'(sidx0);
        dst_raddr      = ADDR_W'(idx_r);
        state_nxt      = bitcp_pkg::S_DONE;
        case (op_r)
          bitcp_pkg::OP_WR_SRC: src_we = idx_ok;
          bitcp_pkg::OP_WR_DST: dst_we = idx_ok;
          bitcp_pkg::OP_RD_DST: begin
            if (idx_ok) begin
              state_nxt = bitcp_pkg::S_RD_WAIT;
            end
          end
          bitcp_pkg::OP_COPY: begin
            if (cnt_r == '0) begin
              res_status_nxt = bitcp_pkg::ST_OK;
            end else if (wr_oob) begin
              res_status_nxt = bitcp_pkg::ST_WR_OOB;
            end else if (rd_oob) begin
              res_status_nxt = bitcp_pkg::ST_RD_OOB;
            end else begin
              geom_nxt.sh    = diff[bitcp_pkg::SH_W-1:0];
              geom_nxt.first = w_ext;
              geom_nxt.stop  = stop;
              wi_nxt         = w_ext[bitcp_pkg::POS_W-1:bitcp_pkg::SH_W];
              last_wi_nxt    = stop_m1[bitcp_pkg::POS_W-1:bitcp_pkg::SH_W];
              sidx_nxt       = sidx0 + bitcp_pkg::SIDX_W'(1);
              state_nxt      = bitcp_pkg::S_CP_PLD;
            end
          end
          default: ;
        endcase
      end
      bitcp_pkg::S_RD_WAIT: begin
        res_data_nxt = dst_rdata;
        state_nxt    = bitcp_pkg::S_DONE;
      end
      bitcp_pkg::S_CP_PLD: begin
        dp_ctrl.load_lo = 1'b1;
        state_nxt       = bitcp_pkg::S_CP_LD;
      end
      bitcp_pkg::S_CP_LD: begin
        dp_ctrl.load_hi = 1'b1;
        dig_nxt         = '0;
        state_nxt       = bitcp_pkg::S_CP_DIG;
      end
      bitcp_pkg::S_CP_DIG: begin
        dp_ctrl.shift = 1'b1;
        dig_nxt       = dig_r + bitcp_pkg::DIG_CNT_W'(1);
        if (dig_r == bitcp_pkg::DIG_CNT_W'(bitcp_pkg::DIGITS - 1)) begin
          state_nxt = bitcp_pkg::S_CP_WR;
        end
      end
      bitcp_pkg::S_CP_WR: begin
        dst_we    = 1'b1;
        dst_waddr = ADDR_W'(wi_r);
        dst_wdata = merged_word;
        src_raddr = ADDR_W'(sidx_r + bitcp_pkg::SIDX_W'(1));
        dst_raddr = ADDR_W'(wi_r + bitcp_pkg::WI_W'(1));
        if (wi_r == last_wi_r) begin
          state_nxt = bitcp_pkg::S_DONE;
        end else begin
          wi_nxt    = wi_r + bitcp_pkg::WI_W'(1);
          sidx_nxt  = sidx_r + bitcp_pkg::SIDX_W'(1);
          state_nxt = bitcp_pkg::S_CP_LD;
        end
      end
      bitcp_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(bitcp_pkg::OUT_DATA_W - bitcp_pkg::WORD_W
                              - bitcp_pkg::STATUS_W){1'b0}},
                            res_status_r, res_data_r};
          state_nxt      = bitcp_pkg::S_IDLE;
        end
      end
      default: state_nxt = bitcp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bitcp_pkg::S_CLEAR;
      clr_addr_r   <= '0;
      dlen_r       <= bitcp_pkg::LEN_RESET;
      slen_r       <= bitcp_pkg::LEN_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      dlen_r       <= dlen_nxt;
      slen_r       <= slen_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= bitcp_pkg::op_t'(in_tuser);
      idx_r  <= in_tdata[3:0];
      val_r  <= in_tdata[67:4];
      cnt_r  <= in_tdata[78:68];
      woff_r <= in_tdata[89:79];
      roff_r <= in_tdata[100:90];
    end
    geom_r       <= geom_nxt;
    wi_r         <= wi_nxt;
    last_wi_r    <= last_wi_nxt;
    sidx_r       <= sidx_nxt;
    dig_r        <= dig_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  bitcp_ram #(
    .DEPTH  (BITMAP_WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (bitcp_pkg::WORD_W)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  bitcp_ram #(
    .DEPTH  (BITMAP_WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (bitcp_pkg::WORD_W)
  ) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .raddr (dst_raddr),
    .rdata (dst_rdata)
  );

  bitcp_align u_align (
    .clk         (clk),
    .ctrl        (dp_ctrl),
    .geom        (geom_r),
    .wi          (wi_r),
    .dig         (dig_r),
    .src_word    (src_rdata),
    .dst_word    (dst_rdata),
    .merged_word (merged_word)
  );

`ifndef ASSERT_OFF
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == bitcp_pkg::S_DONE))
    else $error("result raised outside completion");

  a_copy_word_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bitcp_pkg::S_CP_WR) |-> (int'(wi_r) < BITMAP_WORDS))
    else $error("copy writes past the destination store");

  a_copy_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bitcp_pkg::S_CP_WR && wi_r == last_wi_r) |=> (state_r == bitcp_pkg::S_DONE))
    else $error("copy did not finish at its last word");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bitcp_pkg::S_CLEAR) |-> (!out_tvalid_r && !in_tready))
    else $error("traffic during clearing pass");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for bit_range_copy_core: word writes, word reads and bit range copies.
// Predicts every result from its own copy of both bitmaps and the length registers.
// Depends on bitcp_pkg and bit_range_copy_core.
`timescale 1ns / 1ps

module tb;

  localparam int CAP_BITS    = bitcp_pkg::DEF_BITMAP_WORDS * bitcp_pkg::WORD_W;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    bitcp_pkg::op_t                 op;
    logic [bitcp_pkg::IDX_W-1:0]    idx;
    logic [bitcp_pkg::WORD_W-1:0]   value;
    logic [bitcp_pkg::LEN_W-1:0]    count;
    logic [bitcp_pkg::LEN_W-1:0]    woff;
    logic [bitcp_pkg::LEN_W-1:0]    roff;
  } bitmap_cmd_t;

  typedef struct {
    logic [bitcp_pkg::WORD_W-1:0] data;
    bitcp_pkg::status_t           status;
  } bitmap_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [bitcp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [bitcp_pkg::OP_W-1:0]       in_tuser = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bitcp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bitcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bitcp_pkg::LEN_W-1:0]      cfg_data = '0;

  logic [bitcp_pkg::WORD_W-1:0] src_mem [bitcp_pkg::DEF_BITMAP_WORDS] = '{default: '0};
  logic [bitcp_pkg::WORD_W-1:0] dst_mem [bitcp_pkg::DEF_BITMAP_WORDS] = '{default: '0};
  logic [bitcp_pkg::LEN_W-1:0]  dest_len_reg = bitcp_pkg::LEN_RESET;
  logic [bitcp_pkg::LEN_W-1:0]  src_len_reg = bitcp_pkg::LEN_RESET;

  bitmap_cmd_t    cmd_queue[$];
  bitmap_result_t expected_results[$];
  bitmap_cmd_t    cmd_on_bus;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;
  int stall_cycles = 0;

  bit_range_copy_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bitmap_result_t run_bitmap_op(bitmap_cmd_t c);
    bitmap_result_t res;
    int dl;
    int sl;
    int d;
    int s;
    res.data = '0;
    res.status = bitcp_pkg::ST_OK;
    case (c.op)
      bitcp_pkg::OP_WR_SRC: src_mem[c.idx] = c.value;
      bitcp_pkg::OP_WR_DST: dst_mem[c.idx] = c.value;
      bitcp_pkg::OP_RD_DST: res.data = dst_mem[c.idx];
      default: begin
        if (c.count != 0) begin
          dl = (int'(dest_len_reg) > CAP_BITS) ? CAP_BITS : int'(dest_len_reg);
          sl = (int'(src_len_reg) > CAP_BITS) ? CAP_BITS : int'(src_len_reg);
          if (int'(c.woff) + int'(c.count) > dl) begin
            res.status = bitcp_pkg::ST_WR_OOB;
          end else if (int'(c.roff) + int'(c.count) > sl) begin
            res.status = bitcp_pkg::ST_RD_OOB;
          end else begin
            for (int i = 0; i < int'(c.count); i++) begin
              d = int'(c.woff) + i;
              s = int'(c.roff) + i;
              dst_mem[d / bitcp_pkg::WORD_W][d % bitcp_pkg::WORD_W] =
                src_mem[s / bitcp_pkg::WORD_W][s % bitcp_pkg::WORD_W];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic bitmap_cmd_t random_cmd();
    bitmap_cmd_t c;
    int pick;
    int dl;
    int sl;
    int lim;
    pick = $urandom_range(99);
    c.idx = bitcp_pkg::IDX_W'($urandom_range(bitcp_pkg::DEF_BITMAP_WORDS - 1));
    c.value = {$urandom, $urandom};
    if ($urandom_range(19) == 0) c.value = '0;
    else if ($urandom_range(19) == 0) c.value = '1;
    c.count = bitcp_pkg::LEN_W'($urandom_range(CAP_BITS));
    c.woff = bitcp_pkg::LEN_W'($urandom_range(CAP_BITS));
    c.roff = bitcp_pkg::LEN_W'($urandom_range(CAP_BITS));
    if (pick < 20) c.op = bitcp_pkg::OP_WR_SRC;
    else if (pick < 35) c.op = bitcp_pkg::OP_WR_DST;
    else if (pick < 50) c.op = bitcp_pkg::OP_RD_DST;
    else begin
      c.op = bitcp_pkg::OP_COPY;
      dl = (int'(dest_len_reg) > CAP_BITS) ? CAP_BITS : int'(dest_len_reg);
      sl = (int'(src_len_reg) > CAP_BITS) ? CAP_BITS : int'(src_len_reg);
      lim = (dl < sl) ? dl : sl;
      // keep most copies in bounds so the copy path gets real work
      if (lim > 0 && $urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 60)
          c.count = bitcp_pkg::LEN_W'($urandom_range((lim < 130) ? lim : 130, 1));
        else if (pick < 85) c.count = bitcp_pkg::LEN_W'($urandom_range(lim));
        else if (pick < 95) c.count = bitcp_pkg::LEN_W'(lim);
        else c.count = '0;
        c.woff = bitcp_pkg::LEN_W'($urandom_range(dl - int'(c.count)));
        c.roff = bitcp_pkg::LEN_W'($urandom_range(sl - int'(c.count)));
      end
    end
    return c;
  endfunction

  task automatic queue_cmd(input bitcp_pkg::op_t op, input int idx,
                           input logic [bitcp_pkg::WORD_W-1:0] value,
                           input int count, input int woff, input int roff);
    bitmap_cmd_t c;
    c.op = op;
    c.idx = bitcp_pkg::IDX_W'(idx);
    c.value = value;
    c.count = bitcp_pkg::LEN_W'(count);
    c.woff = bitcp_pkg::LEN_W'(woff);
    c.roff = bitcp_pkg::LEN_W'(roff);
    cmd_queue.push_back(c);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_lengths(input int dlen, input int slen);
    cfg_valid <= 1'b1;
    cfg_index <= bitcp_pkg::REG_DEST_LEN;
    cfg_data <= bitcp_pkg::LEN_W'(dlen);
    do @(posedge clk); while (!cfg_ready);
    dest_len_reg = bitcp_pkg::LEN_W'(dlen);
    cfg_index <= bitcp_pkg::REG_SRC_LEN;
    cfg_data <= bitcp_pkg::LEN_W'(slen);
    do @(posedge clk); while (!cfg_ready);
    src_len_reg = bitcp_pkg::LEN_W'(slen);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int dlen, input int slen, input int items);
    set_lengths(dlen, slen);
    for (int i = 0; i < items; i++) cmd_queue.push_back(random_cmd());
    wait_drained();
  endtask

  // driver: predict on every input transaction, then offer the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(run_bitmap_op(cmd_on_bus));
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cmd_on_bus = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cmd_on_bus.op;
          in_tdata <= {3'b000, cmd_on_bus.roff, cmd_on_bus.woff, cmd_on_bus.count,
                       cmd_on_bus.value, cmd_on_bus.idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    bitmap_result_t want;
    logic [bitcp_pkg::WORD_W-1:0]   got_data;
    logic [bitcp_pkg::STATUS_W-1:0] got_status;
    if (rst_n && out_tvalid && out_tready) begin
      got_data = out_tdata[bitcp_pkg::WORD_W-1:0];
      got_status = out_tdata[bitcp_pkg::WORD_W +: bitcp_pkg::STATUS_W];
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result read_data=%h status=%0d", $realtime, got_data,
                   got_status);
      end else begin
        want = expected_results.pop_front();
        if (got_data !== want.data || got_status !== want.status) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch read_data exp=%h got=%h status exp=%0d got=%0d",
                     $realtime, want.data, got_data, want.status, got_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("bit_range_copy_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct <= 11;
    receiver_idle_pct <= 87;

    queue_cmd(bitcp_pkg::OP_WR_SRC, 0, '1, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_WR_SRC, 15, 64'hA5A5_5A5A_F00F_0FF0, 1024, 1024, 1024);
    queue_cmd(bitcp_pkg::OP_WR_SRC, 7, {$urandom, $urandom}, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_WR_DST, 0, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_WR_DST, 15, '1, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_WR_DST, 3, 64'h0123_4567_89AB_CDEF, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 0, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 15, '1, 1024, 1024, 1024);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 0, 1024, 1024);
    queue_cmd(bitcp_pkg::OP_COPY, 15, '1, 1, 1023, 1023);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 1024, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 15, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 3, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 1024, 1, 0);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 1, 1024, 0);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 1, 0, 1024);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 1024, 1024, 1024);
    queue_cmd(bitcp_pkg::OP_WR_DST, 8, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_WR_DST, 1, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 200, 37, 5);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 64, 64, 63);
    queue_cmd(bitcp_pkg::OP_COPY, 0, '0, 63, 1, 960);
    queue_cmd(bitcp_pkg::OP_RD_DST, 0, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 1, '0, 0, 0, 0);
    queue_cmd(bitcp_pkg::OP_RD_DST, 8, '0, 0, 0, 0);
    wait_drained();

    run_phase(1024, 1024, 250);
    run_phase(0, 0, 60);
    run_phase(2047, 2047, 200);

    sender_idle_pct <= 87;
    receiver_idle_pct <= 11;
    run_phase(640, 1000, 250);
    run_phase(1, 65, 80);
    run_phase(1024, 64, 200);

    sender_idle_pct <= 0;
    receiver_idle_pct <= 0;
    hold_token <= hold_token + 1;
    run_phase(2047, 1024, 250);
    run_phase($urandom_range(2047), $urandom_range(2047), 235);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("bit_range_copy_core test passed");
    end else begin
      $display("bit_range_copy_core test failed");
    end
    $finish;
  end

endmodule
